[rtl/pbrt_pkg.sv]
// shared constants and types of the piece block request tracker
package pbrt_pkg;

  localparam int MAX_BLOCKS = 64;

  // fixed field widths
  localparam int PNUM_W     = 32;
  localparam int PSIZE_W    = 25;
  localparam int BSIZE_W    = 18;
  localparam int OFFSET_W   = 24;
  localparam int LENGTH_W   = 18;
  localparam int OP_W       = 3;
  localparam int PEND_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // largest block size the register holds
  localparam int BSIZE_MAX = (1 << BSIZE_W) - 1;

  // block counter and running offset widths
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int SPAN_W = $clog2(MAX_BLOCKS * BSIZE_MAX + 1);
  localparam int OFF_W  = (SPAN_W > PSIZE_W) ? SPAN_W : PSIZE_W;

  localparam logic [PSIZE_W-1:0] PIECE_SIZE_RST = PSIZE_W'(262144);
  localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = BSIZE_W'(16384);

  localparam logic [CFG_IDX_W-1:0] REG_PIECE_NUMBER   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PIECE_SIZE     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCK_SIZE = CFG_IDX_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_START  = 3'd0,
    OP_GET    = 3'd1,
    OP_CANCEL = 3'd2,
    OP_ADD    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_REMOVED   = 2'd0,
    ST_FREE      = 2'd1,
    ST_REQUESTED = 2'd2,
    ST_RECEIVED  = 2'd3
  } status_t;

endpackage

[rtl/pbrt_cell.sv]
// one status cell of the rotating block status ring
module pbrt_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift_en,
  input  pbrt_pkg::status_t d,
  output pbrt_pkg::status_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= pbrt_pkg::ST_REMOVED;
    end else if (shift_en) begin
      q <= d;
    end
  end

endmodule

[rtl/piece_block_request_tracker.sv]
// top level of the piece block request tracker: status ring, head unit and control
//
// Tracks the blocks of one piece in a ring of MAX_BLOCKS two-bit status cells.
// Every request (start, get_request, cancel_pending, add_data, clear_requests)
// rotates the whole ring once: each cycle every cell hands its status to its
// neighbour, and the head unit at the end of the ring inspects the status of
// block k, rewrites it and feeds it back in at the start, while it steps the
// running block offset by the latched block size. Each request is accepted,
// rotated once through the ring, and its result is posted when the output
// register is free. The rotation also carries the split of a start: a block
// exists where its offset lies inside the piece, and the start overflows when
// MAX_BLOCKS blocks still do not reach the piece end, so no divider is needed.
// A new request is taken as soon as the previous result is in the output
// register, even if that result has not been taken yet.
// Configuration registers are written through a plain write port and only
// take effect at the next start.
module piece_block_request_tracker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [pbrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbrt_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pbrt_pkg::OP_W-1:0]       op,
  input  logic [pbrt_pkg::OFFSET_W-1:0]   offset,
  input  logic [pbrt_pkg::LENGTH_W-1:0]   length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            found,
  output logic [pbrt_pkg::PNUM_W-1:0]     out_piece_number,
  output logic [pbrt_pkg::OFFSET_W-1:0]   out_offset,
  output logic [pbrt_pkg::LENGTH_W-1:0]   out_length,
  output logic                            complete,
  output logic [pbrt_pkg::PEND_W-1:0]     pending_count,
  output logic                            overflow_error
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [pbrt_pkg::PNUM_W-1:0]  cfg_piece_number;
  logic [pbrt_pkg::PSIZE_W-1:0] cfg_piece_size;
  logic [pbrt_pkg::BSIZE_W-1:0] cfg_block_size;

  // values latched at start
  logic [pbrt_pkg::PNUM_W-1:0]  pnum_latch;
  logic [pbrt_pkg::PSIZE_W-1:0] piece_latch;
  logic [pbrt_pkg::BSIZE_W-1:0] size_latch;
  logic [pbrt_pkg::CNT_W-1:0]   block_count;
  logic                         overflow;

  // request being worked on
  pbrt_pkg::op_t                 scan_op;
  logic [pbrt_pkg::OFFSET_W-1:0] req_offset;
  logic [pbrt_pkg::LENGTH_W-1:0] req_length;

  // sweep state
  logic [pbrt_pkg::CNT_W-1:0]    scan_idx;
  logic [pbrt_pkg::OFF_W-1:0]    cur_off;
  logic                          hit_seen;
  logic                          freed_any;
  logic [pbrt_pkg::OFFSET_W-1:0] hit_off;
  logic [pbrt_pkg::LENGTH_W-1:0] hit_len;
  logic [pbrt_pkg::CNT_W-1:0]    pend_acc;
  logic [pbrt_pkg::CNT_W-1:0]    need_acc;
  logic                          incomplete;

  // status ring
  pbrt_pkg::status_t cell_q [pbrt_pkg::MAX_BLOCKS];
  pbrt_pkg::status_t tail;
  pbrt_pkg::status_t status_next;
  logic              shift_en;

  // head unit signals
  logic                       in_piece;
  logic [pbrt_pkg::OFF_W-1:0] rest;
  logic [pbrt_pkg::OFF_W-1:0] blk_len;
  logic                       live;
  logic                       hit;
  logic                       freed;
  logic                       count_pend;
  logic                       count_open;
  logic                       last_step;
  logic                       start_bad;

  // result goes into the output register this cycle
  logic                       result_load;

  assign in_ready    = (state == S_IDLE) && !rst;
  assign shift_en    = (state == S_SCAN);
  assign tail        = cell_q[pbrt_pkg::MAX_BLOCKS-1];
  assign last_step   = (scan_idx == pbrt_pkg::CNT_W'(pbrt_pkg::MAX_BLOCKS - 1));
  assign result_load = (state == S_FINISH) && (!out_valid || out_ready);

  // ring of cells, block k sits at the tail after k shifts
  for (genvar i = 0; i < pbrt_pkg::MAX_BLOCKS; i++) begin : g_cell
    if (i == 0) begin : g_first
      pbrt_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (shift_en),
        .d        (status_next),
        .q        (cell_q[i])
      );
    end else begin : g_rest
      pbrt_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (shift_en),
        .d        (cell_q[i-1]),
        .q        (cell_q[i])
      );
    end
  end

  // block geometry at the running offset
  assign in_piece = (cur_off < pbrt_pkg::OFF_W'(piece_latch));
  assign rest     = pbrt_pkg::OFF_W'(piece_latch) - cur_off;
  assign live     = (scan_idx < block_count);

  always_comb begin
    if (!in_piece) begin
      blk_len = '0;
    end else if (rest > pbrt_pkg::OFF_W'(size_latch)) begin
      blk_len = pbrt_pkg::OFF_W'(size_latch);
    end else begin
      blk_len = rest;
    end
  end

  // head unit: inspect and rewrite the status leaving the ring
  always_comb begin
    status_next = tail;
    hit         = 1'b0;
    freed       = 1'b0;
    unique case (scan_op)
      pbrt_pkg::OP_START: begin
        status_next = in_piece ? pbrt_pkg::ST_FREE : pbrt_pkg::ST_REMOVED;
      end
      pbrt_pkg::OP_GET: begin
        if (live && !hit_seen && tail == pbrt_pkg::ST_FREE) begin
          hit         = 1'b1;
          status_next = pbrt_pkg::ST_REQUESTED;
        end
      end
      pbrt_pkg::OP_CANCEL: begin
        if (live && !hit_seen && tail == pbrt_pkg::ST_REQUESTED) begin
          hit         = 1'b1;
          status_next = pbrt_pkg::ST_REMOVED;
        end
      end
      pbrt_pkg::OP_ADD: begin
        if (live && !hit_seen &&
            (tail == pbrt_pkg::ST_REQUESTED || tail == pbrt_pkg::ST_RECEIVED) &&
            cur_off == pbrt_pkg::OFF_W'(req_offset) &&
            blk_len == pbrt_pkg::OFF_W'(req_length)) begin
          hit         = 1'b1;
          status_next = pbrt_pkg::ST_RECEIVED;
        end
      end
      pbrt_pkg::OP_CLEAR: begin
        if (live && tail == pbrt_pkg::ST_REQUESTED) begin
          freed       = 1'b1;
          status_next = pbrt_pkg::ST_FREE;
        end
      end
      default: begin
        status_next = tail;
      end
    endcase
  end

  // tallies over the rewritten statuses of live blocks
  assign count_pend = live && (status_next == pbrt_pkg::ST_REQUESTED);
  assign count_open = live && (status_next == pbrt_pkg::ST_FREE ||
                               status_next == pbrt_pkg::ST_REQUESTED);

  // after the last step the offset is MAX_BLOCKS block sizes: still inside means overflow
  assign start_bad = in_piece;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      cfg_piece_number <= '0;
      cfg_piece_size   <= pbrt_pkg::PIECE_SIZE_RST;
      cfg_block_size   <= pbrt_pkg::BLOCK_SIZE_RST;
      pnum_latch       <= '0;
      piece_latch      <= '0;
      size_latch       <= '0;
      block_count      <= '0;
      overflow         <= 1'b0;
      scan_op          <= pbrt_pkg::OP_START;
      scan_idx         <= '0;
    end else begin
      // configuration writes, unknown indexes ignored
      if (cfg_wr_en) begin
        priority if (cfg_index == pbrt_pkg::REG_PIECE_NUMBER) begin
          cfg_piece_number <= cfg_wr_data;
        end else if (cfg_index == pbrt_pkg::REG_PIECE_SIZE) begin
          cfg_piece_size <= cfg_wr_data[pbrt_pkg::PSIZE_W-1:0];
        end else if (cfg_index == pbrt_pkg::REG_MAX_BLOCK_SIZE) begin
          cfg_block_size <= cfg_wr_data[pbrt_pkg::BSIZE_W-1:0];
        end
      end

      // a new result replaces a taken one in the same cycle
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            scan_op    <= pbrt_pkg::op_t'(op);
            req_offset <= offset;
            req_length <= length;
            scan_idx   <= '0;
            cur_off    <= '0;
            hit_seen   <= 1'b0;
            freed_any  <= 1'b0;
            hit_off    <= '0;
            hit_len    <= '0;
            pend_acc   <= '0;
            need_acc   <= '0;
            incomplete <= 1'b0;
            if (op == pbrt_pkg::OP_START) begin
              pnum_latch  <= cfg_piece_number;
              piece_latch <= cfg_piece_size;
              size_latch  <= cfg_block_size;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cur_off  <= cur_off + pbrt_pkg::OFF_W'(size_latch);
          scan_idx <= scan_idx + 1'b1;
          if (hit) begin
            hit_seen <= 1'b1;
            hit_off  <= cur_off[pbrt_pkg::OFFSET_W-1:0];
            hit_len  <= blk_len[pbrt_pkg::LENGTH_W-1:0];
          end
          if (freed) begin
            freed_any <= 1'b1;
          end
          pend_acc   <= pend_acc + pbrt_pkg::CNT_W'(count_pend);
          need_acc   <= need_acc + pbrt_pkg::CNT_W'(in_piece);
          incomplete <= incomplete | count_open;
          if (last_step) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (result_load) begin
            if (scan_op == pbrt_pkg::OP_START) begin
              block_count      <= start_bad ? '0 : need_acc;
              overflow         <= start_bad;
              found            <= 1'b0;
              out_piece_number <= '0;
              out_offset       <= '0;
              out_length       <= '0;
              complete         <= start_bad || (need_acc == '0);
              pending_count    <= '0;
              overflow_error   <= start_bad;
            end else begin
              found            <= hit_seen | freed_any;
              out_piece_number <= hit_seen ? pnum_latch : '0;
              out_offset       <= hit_off;
              out_length       <= hit_len;
              complete         <= !incomplete;
              pending_count    <= pbrt_pkg::PEND_W'(pend_acc);
              overflow_error   <= overflow;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/pbrt_checker.sv]
// port-level checks of the piece block request tracker, bound to the top level
module pbrt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            found,
  input logic [pbrt_pkg::PNUM_W-1:0]     out_piece_number,
  input logic [pbrt_pkg::OFFSET_W-1:0]   out_offset,
  input logic [pbrt_pkg::LENGTH_W-1:0]   out_length,
  input logic                            complete,
  input logic [pbrt_pkg::PEND_W-1:0]     pending_count,
  input logic                            overflow_error
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_offset) &&
      $stable(out_length) && $stable(pending_count) && $stable(found))
    else $error("result changed while stalled");

  // nothing returned without a matching block
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> out_offset == '0 && out_length == '0 &&
      out_piece_number == '0)
    else $error("block fields set without a hit");

  // an overflowed piece has an empty table
  a_overflow_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow_error |-> pending_count == '0 && complete)
    else $error("overflowed piece shows blocks");

  // outstanding requests mean the piece is not complete
  a_pending_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && pending_count != '0 |-> !complete)
    else $error("complete with requests outstanding");

  // pending count bounded by the table size
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending_count <= pbrt_pkg::PEND_W'(pbrt_pkg::MAX_BLOCKS))
    else $error("pending count beyond table size");

endmodule

bind piece_block_request_tracker pbrt_checker u_pbrt_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .found            (found),
  .out_piece_number (out_piece_number),
  .out_offset       (out_offset),
  .out_length       (out_length),
  .complete         (complete),
  .pending_count    (pending_count),
  .overflow_error   (overflow_error)
);

[verif/tracker_result_checker.sv]
`timescale 1ns / 100ps
// result prediction and field-by-field comparison for the piece block request tracker
module tracker_result_checker
  import pbrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [OP_W-1:0]       op,
  input  logic [OFFSET_W-1:0]   offset,
  input  logic [LENGTH_W-1:0]   length,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  found,
  input  logic [PNUM_W-1:0]     out_piece_number,
  input  logic [OFFSET_W-1:0]   out_offset,
  input  logic [LENGTH_W-1:0]   out_length,
  input  logic                  complete,
  input  logic [PEND_W-1:0]     pending_count,
  input  logic                  overflow_error,
  output int                    mismatches,
  output int                    results_due,
  output int                    results_checked
);

  typedef struct packed {
    logic                found;
    logic [PNUM_W-1:0]   piece_number;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic                complete;
    logic [PEND_W-1:0]   pending;
    logic                overflow;
  } tracker_result_t;

  tracker_result_t expected_results [$];

  // register copies and the state latched by the last start
  logic [PNUM_W-1:0]  reg_pnum, lat_pnum;
  logic [PSIZE_W-1:0] reg_psize, lat_psize;
  logic [BSIZE_W-1:0] reg_bsize, lat_bsize;
  status_t            blk_state [MAX_BLOCKS];
  int                 blk_total;
  logic               ovf;

  function automatic longint unsigned span_start(input int k);
    return longint'(k) * lat_bsize;
  endfunction

  function automatic longint unsigned span_len(input int k);
    longint unsigned off, rest;
    off  = span_start(k);
    rest = (off < lat_psize) ? lat_psize - off : 0;
    return (rest > lat_bsize) ? lat_bsize : rest;
  endfunction

  function automatic tracker_result_t predict_request(input logic [OP_W-1:0] code,
                                                      input logic [OFFSET_W-1:0] offs,
                                                      input logic [LENGTH_W-1:0] len);
    tracker_result_t res;
    longint unsigned need, psz, bsz;
    logic bad, hit;
    int waiting;
    res = '0;
    case (code)
      OP_START: begin
        psz  = reg_psize;
        bsz  = reg_bsize;
        need = 0;
        bad  = 1'b0;
        // a zero block size never finishes the split
        if (bsz == 0) bad = (psz != 0);
        else need = (psz + bsz - 1) / bsz;
        if (need > MAX_BLOCKS) bad = 1'b1;
        for (int k = 0; k < MAX_BLOCKS; k++) blk_state[k] = ST_REMOVED;
        lat_pnum  = reg_pnum;
        lat_psize = reg_psize;
        lat_bsize = reg_bsize;
        if (bad) begin
          blk_total = 0;
          ovf       = 1'b1;
        end else begin
          blk_total = int'(need);
          ovf       = 1'b0;
          for (int k = 0; k < blk_total; k++) blk_state[k] = ST_FREE;
        end
      end
      OP_GET, OP_CANCEL, OP_ADD: begin
        for (int k = 0; k < blk_total && !res.found; k++) begin
          if (code == OP_GET) hit = (blk_state[k] == ST_FREE);
          else if (code == OP_CANCEL) hit = (blk_state[k] == ST_REQUESTED);
          else hit = (blk_state[k] == ST_REQUESTED || blk_state[k] == ST_RECEIVED) &&
                     span_start(k) == longint'(offs) && span_len(k) == longint'(len);
          if (hit) begin
            res.found        = 1'b1;
            res.piece_number = lat_pnum;
            res.offset       = OFFSET_W'(span_start(k));
            res.length       = LENGTH_W'(span_len(k));
            if (code == OP_GET) blk_state[k] = ST_REQUESTED;
            else if (code == OP_CANCEL) blk_state[k] = ST_REMOVED;
            else blk_state[k] = ST_RECEIVED;
          end
        end
      end
      OP_CLEAR: begin
        for (int k = 0; k < blk_total; k++) begin
          if (blk_state[k] == ST_REQUESTED) begin
            blk_state[k] = ST_FREE;
            res.found    = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.complete = 1'b1;
    waiting      = 0;
    for (int k = 0; k < blk_total; k++) begin
      if (blk_state[k] == ST_REQUESTED) waiting++;
      if (blk_state[k] == ST_FREE || blk_state[k] == ST_REQUESTED) res.complete = 1'b0;
    end
    res.pending  = PEND_W'(waiting);
    res.overflow = ovf;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t ns  %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    tracker_result_t want;
    if (rst) begin
      reg_pnum  = '0;
      reg_psize = PIECE_SIZE_RST;
      reg_bsize = BLOCK_SIZE_RST;
      lat_pnum  = '0;
      lat_psize = '0;
      lat_bsize = '0;
      blk_total = 0;
      ovf       = 1'b0;
      for (int k = 0; k < MAX_BLOCKS; k++) blk_state[k] = ST_REMOVED;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result with no request waiting, offset", out_offset, '0);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (found !== want.found) flag_mismatch("found", found, want.found);
          if (out_piece_number !== want.piece_number)
            flag_mismatch("out_piece_number", out_piece_number, want.piece_number);
          if (out_offset !== want.offset) flag_mismatch("out_offset", out_offset, want.offset);
          if (out_length !== want.length) flag_mismatch("out_length", out_length, want.length);
          if (complete !== want.complete) flag_mismatch("complete", complete, want.complete);
          if (pending_count !== want.pending)
            flag_mismatch("pending_count", pending_count, want.pending);
          if (overflow_error !== want.overflow)
            flag_mismatch("overflow_error", overflow_error, want.overflow);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PIECE_NUMBER:   reg_pnum  = cfg_wr_data[PNUM_W-1:0];
          REG_PIECE_SIZE:     reg_psize = cfg_wr_data[PSIZE_W-1:0];
          REG_MAX_BLOCK_SIZE: reg_bsize = cfg_wr_data[BSIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_results = {expected_results, predict_request(op, offset, length)};
    end
    results_due = expected_results.size();
  end

endmodule

[verif/piece_block_request_tracker_test.sv]
`timescale 1ns / 100ps
// stimulus, handshake idling and verdict for the piece block request tracker
module piece_block_request_tracker_test;
  import pbrt_pkg::*;

  // op codes the block has no use for, and the register index it ignores
  localparam logic [OP_W-1:0]      OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0]      OP_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int STALL_LIMIT = 4000;  // cycles with no handshake before giving up
  localparam int PHASE_ITEMS = 400;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [OP_W-1:0]       op;
  logic [OFFSET_W-1:0]   offset;
  logic [LENGTH_W-1:0]   length;
  logic                  out_valid;
  logic                  out_ready;
  logic                  found;
  logic [PNUM_W-1:0]     out_piece_number;
  logic [OFFSET_W-1:0]   out_offset;
  logic [LENGTH_W-1:0]   out_length;
  logic                  complete;
  logic [PEND_W-1:0]     pending_count;
  logic                  overflow_error;

  int mismatches, results_due, results_checked;

  // idling mix, changed per phase
  int send_idle_pct = 28;
  int recv_idle_pct = 81;

  // hold-offs asked by the stimulus and served by the receiver
  int holds_asked = 0;
  int holds_done  = 0;

  int requests_sent = 0;
  int starts_sent   = 0;
  int setups        = 0;

  // register values as written, and the geometry the last start latched
  logic [PSIZE_W-1:0] cfg_psize = PIECE_SIZE_RST;
  logic [BSIZE_W-1:0] cfg_bsize = BLOCK_SIZE_RST;
  longint unsigned    lat_psize = 0;
  longint unsigned    lat_bsize = 0;

  piece_block_request_tracker dut (.*);

  tracker_result_checker check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // offer one request, with random idle cycles first, and wait for its handshake
  task automatic send_request(input logic [OP_W-1:0] code, input logic [OFFSET_W-1:0] offs,
                              input logic [LENGTH_W-1:0] len);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    offset   <= offs;
    length   <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // idle fields carry random junk, the block must ignore it
  task automatic send_plain(input logic [OP_W-1:0] code);
    send_request(code, OFFSET_W'($urandom), LENGTH_W'($urandom));
  endtask

  task automatic send_start();
    lat_psize = cfg_psize;
    lat_bsize = cfg_bsize;
    starts_sent++;
    send_plain(OP_START);
  endtask

  // add_data for block k of the latched split, length nudged by skew
  task automatic send_add(input int k, input int skew);
    longint unsigned offs, rest, len;
    offs = longint'(k) * lat_bsize;
    rest = (offs < lat_psize) ? lat_psize - offs : 0;
    len  = (rest > lat_bsize) ? lat_bsize : rest;
    send_request(OP_ADD, OFFSET_W'(offs), LENGTH_W'(len + longint'(skew)));
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // new piece setup, only while the block is idle; junk above the field width now and then
  task automatic program_piece(input logic [PNUM_W-1:0] pnum, input logic [PSIZE_W-1:0] psz,
                               input logic [BSIZE_W-1:0] bsz);
    logic [CFG_DATA_W-1:0] junk;
    drain_results();
    junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;
    write_reg(REG_PIECE_NUMBER, pnum);
    write_reg(REG_PIECE_SIZE, {junk[CFG_DATA_W-1:PSIZE_W], psz});
    write_reg(REG_MAX_BLOCK_SIZE, {junk[CFG_DATA_W-1:BSIZE_W], bsz});
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
    end_writes();
    cfg_psize = psz;
    cfg_bsize = bsz;
    setups++;
  endtask

  // one piece: random geometry, a start, then either a full sweep or a random mix
  task automatic run_session(input bit hold_receiver);
    longint unsigned bsz, psz;
    int r, pick, n, span, j, tmp;
    int order [MAX_BLOCKS];
    r    = $urandom_range(0, 99);
    bsz  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 262143);
    span = $urandom_range(1, MAX_BLOCKS);
    psz  = longint'(span - 1) * bsz + $urandom_range(1, int'(bsz));
    if (r < 2) begin
      // largest piece the register holds
      psz  = 33554431;
      span = MAX_BLOCKS;
    end else if (r < 8) begin
      // a few blocks too many for the table
      psz  = MAX_BLOCKS * bsz + $urandom_range(1, 8 * int'(bsz));
      span = MAX_BLOCKS;
    end else if (r < 12) begin
      psz  = 0;
      span = 1;
    end else if (r < 16) begin
      // zero block size, piece size anything
      bsz  = 0;
      psz  = $urandom_range(0, 33554431);
      span = 1;
    end
    program_piece($urandom, PSIZE_W'(psz), BSIZE_W'(bsz));
    if (hold_receiver) holds_asked++;
    send_start();
    if (r >= 16 && $urandom_range(0, 99) < 15) begin
      // request every block, then hand in the data in shuffled order
      for (int k = 0; k < span; k++) send_plain(OP_GET);
      for (int k = 0; k < span; k++) order[k] = k;
      for (int k = span - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      for (int k = 0; k < span; k++) send_add(order[k], 0);
      send_plain(OP_GET);
      send_plain(OP_CANCEL);
    end else begin
      n = $urandom_range(8, 2 * span + 10);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) send_plain(OP_GET);
        else if (pick < 62) send_add($urandom_range(0, span - 1), 0);
        else if (pick < 66) send_add($urandom_range(0, span - 1), $urandom_range(0, 1) ? 1 : -1);
        else if (pick < 76) send_plain(OP_CANCEL);
        else if (pick < 81) send_plain(OP_CLEAR);
        else if (pick < 84) send_start();
        else if (pick < 88) send_plain(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
        else if (pick < 93) send_request(OP_ADD, OFFSET_W'($urandom), LENGTH_W'($urandom));
        else if (pick < 96) send_add($urandom_range(0, MAX_BLOCKS - 1), 0);
        else if (pick < 98) drain_results();
        else begin
          // piece number changes mid piece: only the next start may pick it up
          drain_results();
          write_reg(REG_PIECE_NUMBER, $urandom);
          end_writes();
        end
      end
    end
  endtask

  // receiver: random out_ready, or a long hold-off when one is asked for
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: any handshake on either side restarts the count
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
    $display("piece_block_request_tracker: mismatch");
    $finish;
  end

  initial begin
    int goal;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    op          = OP_START;
    offset      = '0;
    length      = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table first, then the reset geometry of 16 blocks
    send_plain(OP_GET);
    send_start();
    send_plain(OP_GET);
    send_plain(OP_GET);
    send_add(0, 0);
    send_add(0, 0);                               // already received stays received
    send_add(1, 5);                               // right offset, wrong length
    send_request(OP_ADD, '1, '1);                 // all-ones fields
    send_request(OP_ADD, '0, '0);
    send_plain(OP_CANCEL);                        // drops block 1
    send_plain(OP_GET);
    send_plain(OP_CLEAR);                         // frees block 2
    send_plain(OP_CLEAR);                         // nothing left to free
    send_plain(OP_SPARE_LO);
    send_plain(OP_SPARE_HI);
    // zero piece size: no blocks, complete at once
    program_piece('1, '0, BLOCK_SIZE_RST);
    send_start();
    // zero block size with a non-empty piece: overflow
    program_piece($urandom, PSIZE_W'(5), '0);
    send_start();
    // both zero: empty, overflow cleared
    program_piece($urandom, '0, '0);
    send_start();
    // largest piece and block sizes: far too many blocks
    program_piece($urandom, '1, '1);
    send_start();
    // exactly a full table of the largest blocks
    program_piece('1, PSIZE_W'(MAX_BLOCKS * 262143), '1);
    send_start();
    send_plain(OP_GET);
    // block larger than the piece: one short block
    program_piece($urandom, PSIZE_W'(7), BSIZE_W'(100));
    send_start();
    send_plain(OP_GET);
    send_add(0, 0);

    // random part: three idling mixes, each opening with a receiver hold-off
    goal = requests_sent;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 28 : 0;
      goal += PHASE_ITEMS;
      run_session(1'b1);
      while (requests_sent < goal) run_session(1'b0);
    end

    drain_results();
    repeat (140) @(negedge clk);
    $display("covered %0d requests over %0d piece setups and %0d starts, %0d results compared",
             requests_sent, setups, starts_sent, results_checked);
    $display("with overflow, empty and full-table splits, receiver hold-offs and drained pauses");
    if (mismatches == 0) begin
      $display("piece_block_request_tracker: match");
    end else begin
      $display("piece_block_request_tracker: mismatch");
    end
    $finish;
  end

endmodule
